[rtl/urc_pkg.sv]
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types and constants of the ultrasonic ranger controller: item
// structs, command and register codes, and the echo-to-distance constants.
// ----------------------------------------------------------------------------
package urc_pkg;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ECHO  = 2'd1,
    CMD_REARM = 2'd2
  } urc_cmd_t;

  // Trigger pulse sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_END   = 2'd2
  } urc_phase_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RELOAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LIMIT    = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] TICK_RELOAD_RST    = 16'd4000;
  localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd30;
  localparam logic [15:0] FLASH_LIMIT_RST    = 16'd25000;

  // Echo length in microseconds per centimeter of distance.
  localparam int unsigned CM_DIVISOR = 58;

  // Echo lengths below CM_DIVISOR * 2^16 give an unsaturated distance and
  // fit in DIST_LEN_W bits.
  localparam int unsigned DIST_LEN_W   = 22;
  localparam logic [DIST_LEN_W-1:0] DIST_SAT_LEN = DIST_LEN_W'(CM_DIVISOR * 65536);
  localparam logic [DIST_LEN_W-1:0] REARM_LEN    = DIST_LEN_W'(CM_DIVISOR * 100);
  localparam logic [DIST_LEN_W-1:0] NEAR_LEN_RST = DIST_LEN_W'(CM_DIVISOR * 30);

  // Reciprocal of CM_DIVISOR: ceil(2^28 / 58), exact for lengths below 2^22.
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(((1 << RECIP_SHIFT) + CM_DIVISOR - 1)
                                                      / CM_DIVISOR);

  // Flasher counter width; reloads never exceed 2^17 - 1.
  localparam int unsigned FLASH_W = 17;

  // One input item.
  typedef struct packed {
    logic [1:0]  command;
    logic        echo_level;
    logic [31:0] time_us;
  } urc_in_t;

  // One result item.
  typedef struct packed {
    logic        trigger_level;
    logic        led_level;
    logic [15:0] distance_cm;
    logic        clear_way;
    logic        echo_armed;
  } urc_out_t;

  // Block state after an item, handed to the output stage.
  typedef struct packed {
    logic                  trigger_level;
    logic                  led_level;
    logic                  clear_way;
    logic                  echo_armed;
    logic                  dist_sat;
    logic [DIST_LEN_W-1:0] dist_len;
  } urc_snap_t;

endpackage

[rtl/urc_out_stage.sv]
// ----------------------------------------------------------------------------
// urc_out_stage
// Result register of the ranger: converts the stored echo length into
// centimeters by reciprocal multiplication and holds the result item.
// ----------------------------------------------------------------------------
module urc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              snap_valid,
  input  urc_pkg::urc_snap_t snap,
  output logic              snap_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output urc_pkg::urc_out_t out_item
);

  localparam int unsigned PROD_W = urc_pkg::DIST_LEN_W + urc_pkg::RECIP_W;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  urc_pkg::urc_out_t    out_item_r;
  urc_pkg::urc_out_t    out_item_nxt;
  logic [PROD_W-1:0]    prod;
  logic [15:0]          quotient;
  logic                 load;

  // The stage takes a new item when it is empty or its item leaves now.
  assign snap_ready = !out_valid_r || out_ready;
  assign load       = snap_valid && snap_ready;

  // Divide by the centimeter constant through its reciprocal.
  assign prod     = PROD_W'(snap.dist_len) * PROD_W'(urc_pkg::RECIP_MUL);
  assign quotient = prod[urc_pkg::RECIP_SHIFT +: 16];

  // Assemble the result item.
  always_comb begin
    out_item_nxt.trigger_level = snap.trigger_level;
    out_item_nxt.led_level     = snap.led_level;
    out_item_nxt.distance_cm   = snap.dist_sat ? 16'hFFFF : quotient;
    out_item_nxt.clear_way     = snap.clear_way;
    out_item_nxt.echo_armed    = snap.echo_armed;
  end

  // Valid flag of the result register.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // The reciprocal product gives the exact floor quotient.
  a_dist_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !snap.dist_sat) |=>
      (({6'b0, out_item_r.distance_cm} * urc_pkg::DIST_LEN_W'(urc_pkg::CM_DIVISOR))
         <= $past(snap.dist_len)) &&
      ($past(snap.dist_len) <
         (({6'b0, out_item_r.distance_cm} + 22'd1)
          * urc_pkg::DIST_LEN_W'(urc_pkg::CM_DIVISOR))))
    else $error("distance does not match echo length");

  // A saturated length shows the full-scale distance.
  a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (load && snap.dist_sat) |=> (out_item_r.distance_cm == 16'hFFFF))
    else $error("saturated distance not at full scale");
`endif

endmodule

[rtl/ultrasonic_ranger_controller_unit.sv]
// ----------------------------------------------------------------------------
// ultrasonic_ranger_controller_unit
// Trigger scheduling, LED flasher and echo timing of an ultrasonic ranger.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries a command: a timer tick, an echo level change with its
//   microsecond timestamp, or a rearm. Every accepted input item yields one
//   result item on out_item showing trigger and LED levels, the last
//   distance in centimeters, the path-clear flag and the echo-armed flag.
//   Both channels use valid/ready. An accepted item first updates the state
//   registers; the result register then converts the echo length to
//   centimeters and raises out_valid. One item per cycle is sustained while
//   the receiver does not stall; the reciprocal multiplier in the result
//   stage sets the critical path.
//   When the receiver stalls, the result register and the state stage hold
//   one item each, so two items are absorbed before in_ready drops.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while idle, a
//   rule for the user that the block does not enforce. Reset (synchronous,
//   active low) restores register defaults (reload 4000, threshold 30,
//   flash limit 25000), arms echo detection and clears the remaining state.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_controller_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  urc_pkg::urc_in_t                  in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output urc_pkg::urc_out_t                 out_item,
  input  logic                              cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned LW = urc_pkg::DIST_LEN_W;
  localparam int unsigned FW = urc_pkg::FLASH_W;

  // Configuration registers; the threshold is kept as an echo length.
  logic [15:0]   reload_r;
  logic [LW-1:0] near_len_r;
  logic [15:0]   flash_limit_r;

  // Block state.
  logic [15:0]          cd_r, cd_nxt;
  urc_pkg::urc_phase_t  phase_r, phase_nxt;
  logic                 trig_r, trig_nxt;
  logic [31:0]          start_r, start_nxt;
  logic [15:0]          echo_len_r, echo_len_nxt;
  logic                 echo_big_r, echo_big_nxt;
  logic [LW-1:0]        dist_len_r, dist_len_nxt;
  logic                 dist_sat_r, dist_sat_nxt;
  logic                 clear_r, clear_nxt;
  logic                 armed_r, armed_nxt;
  logic [FW-1:0]        flash_r, flash_nxt;
  logic                 led_r, led_nxt;
  logic                 s1_valid_r, s1_valid_nxt;

  // Working signals.
  logic                 in_fire;
  logic                 snap_ready;
  urc_pkg::urc_snap_t   snap;
  logic [15:0]          cd_dec;
  urc_pkg::urc_phase_t  phase_step;
  logic [31:0]          echo_diff;
  logic                 len_sat;
  logic                 blocked;

  // The state stage accepts when empty or when its item moves on.
  assign in_ready = !s1_valid_r || snap_ready;
  assign in_fire  = in_valid && in_ready;

  // Echo length, saturation and obstacle test without a divider.
  assign echo_diff = in_item.time_us - start_r;
  assign len_sat   = (|echo_diff[31:LW]) || (echo_diff[LW-1:0] >= urc_pkg::DIST_SAT_LEN);
  assign blocked   = (echo_diff >= 32'(urc_pkg::CM_DIVISOR)) &&
                     (echo_diff < 32'(near_len_r));

  // Countdown step and phase after a possible reload.
  assign cd_dec = cd_r - 16'd1;
  always_comb begin
    if (cd_dec == 16'd0) begin
      phase_step = urc_pkg::PH_START;
    end else begin
      phase_step = phase_r;
    end
  end

  // Next state for the accepted item.
  always_comb begin
    cd_nxt       = cd_r;
    phase_nxt    = phase_r;
    trig_nxt     = trig_r;
    start_nxt    = start_r;
    echo_len_nxt = echo_len_r;
    echo_big_nxt = echo_big_r;
    dist_len_nxt = dist_len_r;
    dist_sat_nxt = dist_sat_r;
    clear_nxt    = clear_r;
    armed_nxt    = armed_r;
    flash_nxt    = flash_r;
    led_nxt      = led_r;
    if (in_fire) begin
      case (in_item.command)
        urc_pkg::CMD_TICK: begin
          // Trigger countdown and one-tick pulse.
          cd_nxt = (cd_dec == 16'd0) ? reload_r : cd_dec;
          case (phase_step)
            urc_pkg::PH_IDLE: begin
              phase_nxt = urc_pkg::PH_IDLE;
            end
            urc_pkg::PH_START: begin
              trig_nxt  = 1'b1;
              phase_nxt = urc_pkg::PH_END;
            end
            default: begin
              trig_nxt  = 1'b0;
              phase_nxt = urc_pkg::PH_IDLE;
            end
          endcase
          // LED flasher: period follows the last echo length.
          if (flash_r[FW-1:1] == '0) begin
            if (!echo_big_r && (echo_len_r < flash_limit_r)) begin
              flash_nxt = {echo_len_r, 1'b0};
            end else begin
              flash_nxt = FW'(flash_limit_r);
            end
            led_nxt = !led_r;
          end else begin
            flash_nxt = flash_r - FW'(1);
          end
        end
        urc_pkg::CMD_ECHO: begin
          if (armed_r) begin
            if (in_item.echo_level) begin
              start_nxt = in_item.time_us;
            end else begin
              echo_len_nxt = echo_diff[15:0];
              echo_big_nxt = |echo_diff[31:16];
              dist_len_nxt = echo_diff[LW-1:0];
              dist_sat_nxt = len_sat;
              if (blocked) begin
                clear_nxt = 1'b0;
                armed_nxt = 1'b0;
              end else begin
                clear_nxt = 1'b1;
              end
            end
          end
        end
        urc_pkg::CMD_REARM: begin
          dist_len_nxt = urc_pkg::REARM_LEN;
          dist_sat_nxt = 1'b0;
          armed_nxt    = 1'b1;
        end
        default: begin
          // Unused command code leaves the state alone.
        end
      endcase
    end
  end

  // Valid flag of the state stage.
  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (snap_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r       <= '0;
      phase_r    <= urc_pkg::PH_IDLE;
      trig_r     <= 1'b0;
      start_r    <= '0;
      echo_len_r <= '0;
      echo_big_r <= 1'b0;
      dist_len_r <= '0;
      dist_sat_r <= 1'b0;
      clear_r    <= 1'b0;
      armed_r    <= 1'b1;
      flash_r    <= '0;
      led_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      cd_r       <= cd_nxt;
      phase_r    <= phase_nxt;
      trig_r     <= trig_nxt;
      start_r    <= start_nxt;
      echo_len_r <= echo_len_nxt;
      echo_big_r <= echo_big_nxt;
      dist_len_r <= dist_len_nxt;
      dist_sat_r <= dist_sat_nxt;
      clear_r    <= clear_nxt;
      armed_r    <= armed_nxt;
      flash_r    <= flash_nxt;
      led_r      <= led_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Configuration writes; the threshold is scaled to an echo length here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r      <= urc_pkg::TICK_RELOAD_RST;
      near_len_r    <= urc_pkg::NEAR_LEN_RST;
      flash_limit_r <= urc_pkg::FLASH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        urc_pkg::CFG_TICK_RELOAD: begin
          reload_r <= cfg_wdata;
        end
        urc_pkg::CFG_NEAR_THRESHOLD: begin
          near_len_r <= LW'(cfg_wdata) * LW'(urc_pkg::CM_DIVISOR);
        end
        urc_pkg::CFG_FLASH_LIMIT: begin
          flash_limit_r <= cfg_wdata;
        end
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // State after the item, as seen by the result stage.
  always_comb begin
    snap.trigger_level = trig_r;
    snap.led_level     = led_r;
    snap.clear_way     = clear_r;
    snap.echo_armed    = armed_r;
    snap.dist_sat      = dist_sat_r;
    snap.dist_len      = dist_len_r;
  end

  urc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (s1_valid_r),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

`ifndef ASSERT_OFF
  // Echo detection is disarmed only by a falling echo edge.
  a_disarm_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(armed_r) |-> $past(in_fire && (in_item.command == urc_pkg::CMD_ECHO) &&
                             !in_item.echo_level))
    else $error("echo detection disarmed without a falling edge");

  // While disarmed, the path is reported blocked.
  a_disarmed_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> !clear_r)
    else $error("path clear while echo detection is disarmed");

  // An unsaturated stored length stays inside the exact-division range.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    !dist_sat_r |-> (dist_len_r < urc_pkg::DIST_SAT_LEN))
    else $error("stored echo length out of range");
`endif

endmodule
